/* src/lfatc_pkg.sv */
// ----------------------------------------------------------------------------
// LRU tag cache package
// Shared widths, reset values and sequencer state type for the tag cache.
// ----------------------------------------------------------------------------
package lfatc_pkg;

    localparam int unsigned CFG_W = 5;
    localparam int unsigned SLOT_W = 4;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_WRITE,
        S_DONE
    } t_state;

endpackage

/* src/lfatc_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module lfatc_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/lru_fully_associative_tag_cache.sv */
// ----------------------------------------------------------------------------
// LRU fully associative tag cache
// Tag directory of a small fully associative cache keyed by fragment id,
// with least recently used replacement by timestamp.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Payload
//  request   in         i_valid / o_ready      i_op, i_fragment, i_now
//  result    out        o_valid / i_ready      o_hit, o_slot, o_stored
//  config    in         i_cfg_we               i_cfg_wdata
//
// A lookup scans the slots in use before the next request can be taken: one
// tag and timestamp pair is read per cycle from the RAMs and checked by a
// single compare unit, then the picked slot is written and the result loaded.
// A clear, or a lookup with no slots in use, goes straight to the result.
// Reset is synchronous; it invalidates all slots and zeroes all timestamps.
// A waiting result does not block acceptance of the next request; a finished
// request waits only if the previous result has not yet been taken.
// ----------------------------------------------------------------------------
module lru_fully_associative_tag_cache #(
    parameter int unsigned MAX_ENTRIES = 16,
    parameter int unsigned FRAG_BITS = 16,
    parameter int unsigned TIME_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_op,
    input  logic [FRAG_BITS-1:0]        i_fragment,
    input  logic [TIME_BITS-1:0]        i_now,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_hit,
    output logic [lfatc_pkg::SLOT_W-1:0] o_slot,
    output logic                        o_stored,
    input  logic                        i_cfg_we,
    input  logic [lfatc_pkg::CFG_W-1:0] i_cfg_wdata
);

    localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned EXT_W = (CNT_W > lfatc_pkg::CFG_W) ? CNT_W : lfatc_pkg::CFG_W;
    localparam int unsigned PW = (IDX_W > lfatc_pkg::SLOT_W) ? IDX_W : lfatc_pkg::SLOT_W;

    lfatc_pkg::t_state r_state, n_state;

    logic [lfatc_pkg::CFG_W-1:0] r_cfg;
    logic [MAX_ENTRIES-1:0]      r_slot_valid;
    logic [MAX_ENTRIES-1:0]      r_stamp_wr;
    logic [FRAG_BITS-1:0]        r_frag;
    logic [TIME_BITS-1:0]        r_now;
    logic [IDX_W-1:0]            r_idx;
    logic [IDX_W-1:0]            r_didx;
    logic                        r_dv;
    logic                        r_found;
    logic [IDX_W-1:0]            r_hit_idx;
    logic [IDX_W-1:0]            r_old_idx;
    logic [TIME_BITS-1:0]        r_oldest;
    logic [IDX_W-1:0]            r_pick;
    logic                        r_store;
    logic                        r_out_valid;
    logic                        r_o_hit;
    logic [lfatc_pkg::SLOT_W-1:0] r_o_slot;
    logic                        r_o_stored;

    logic [CNT_W-1:0]     w_active;
    logic                 w_accept;
    logic                 w_out_free;
    logic                 w_last_issue;
    logic [IDX_W-1:0]     w_pick;
    logic [FRAG_BITS-1:0] w_tag_rdata;
    logic [TIME_BITS-1:0] w_time_rdata;
    logic [TIME_BITS-1:0] w_stamp;
    logic                 w_tag_we;
    logic                 w_time_we;
    logic                 w_scan;
    logic                 w_load_out;
    logic [PW-1:0]        w_pick_ext;

    always_comb begin
        if (EXT_W'(r_cfg) > EXT_W'(MAX_ENTRIES)) begin
            w_active = CNT_W'(MAX_ENTRIES);
        end else begin
            w_active = CNT_W'(r_cfg);
        end
    end

    assign w_accept = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;
    assign w_last_issue = (CNT_W'(r_idx) == (w_active - CNT_W'(1)));
    assign w_pick = r_found ? r_hit_idx : r_old_idx;
    assign w_stamp = r_stamp_wr[r_didx] ? w_time_rdata : '0;
    assign w_pick_ext = PW'(r_pick);

    lfatc_ram #(
        .WIDTH(FRAG_BITS),
        .DEPTH(MAX_ENTRIES)
    ) u_tag_ram (
        .i_clk  (i_clk),
        .i_we   (w_tag_we),
        .i_waddr(w_pick),
        .i_wdata(r_frag),
        .i_raddr(r_idx),
        .o_rdata(w_tag_rdata)
    );

    lfatc_ram #(
        .WIDTH(TIME_BITS),
        .DEPTH(MAX_ENTRIES)
    ) u_time_ram (
        .i_clk  (i_clk),
        .i_we   (w_time_we),
        .i_waddr(w_pick),
        .i_wdata(r_now),
        .i_raddr(r_idx),
        .o_rdata(w_time_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lfatc_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (i_op == lfatc_pkg::OP_CLEAR || w_active == '0) begin
                        n_state = lfatc_pkg::S_DONE;
                    end else begin
                        n_state = lfatc_pkg::S_SCAN;
                    end
                end
            end
            lfatc_pkg::S_SCAN: begin
                if (w_last_issue) begin
                    n_state = lfatc_pkg::S_LAST;
                end
            end
            lfatc_pkg::S_LAST: begin
                n_state = lfatc_pkg::S_WRITE;
            end
            lfatc_pkg::S_WRITE: begin
                n_state = lfatc_pkg::S_DONE;
            end
            lfatc_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = lfatc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lfatc_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        w_scan = 1'b0;
        w_tag_we = 1'b0;
        w_time_we = 1'b0;
        w_load_out = 1'b0;
        unique case (r_state)
            lfatc_pkg::S_IDLE: begin
                o_ready = 1'b1;
            end
            lfatc_pkg::S_SCAN: begin
                w_scan = 1'b1;
            end
            lfatc_pkg::S_LAST: begin
            end
            lfatc_pkg::S_WRITE: begin
                w_time_we = 1'b1;
                w_tag_we = !r_found;
            end
            lfatc_pkg::S_DONE: begin
                w_load_out = w_out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lfatc_pkg::S_IDLE;
            r_cfg <= lfatc_pkg::CFG_RESET;
            r_slot_valid <= '0;
            r_stamp_wr <= '0;
            r_dv <= 1'b0;
            r_out_valid <= 1'b0;
            r_found <= 1'b0;
            r_store <= 1'b0;
            r_idx <= '0;
        end else begin
            r_state <= n_state;
            r_dv <= w_scan;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_found <= 1'b0;
                r_idx <= '0;
                r_store <= (i_op == lfatc_pkg::OP_LOOKUP) && (w_active != '0);
                if (i_op == lfatc_pkg::OP_CLEAR) begin
                    r_slot_valid <= '0;
                end
            end
            if (w_scan) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (r_dv && !r_found && r_slot_valid[r_didx] && w_tag_rdata == r_frag) begin
                r_found <= 1'b1;
            end
            if (w_time_we) begin
                r_stamp_wr[w_pick] <= 1'b1;
                r_slot_valid[w_pick] <= 1'b1;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_frag <= i_fragment;
            r_now <= i_now;
            r_pick <= '0;
        end
        if (w_scan) begin
            r_didx <= r_idx;
        end
        if (r_dv) begin
            if (!r_found && r_slot_valid[r_didx] && w_tag_rdata == r_frag) begin
                r_hit_idx <= r_didx;
            end
            if (r_didx == '0 || w_stamp < r_oldest) begin
                r_oldest <= w_stamp;
                r_old_idx <= r_didx;
            end
        end
        if (w_time_we) begin
            r_pick <= w_pick;
        end
        if (w_load_out) begin
            r_o_hit <= r_found && r_store;
            r_o_slot <= w_pick_ext[lfatc_pkg::SLOT_W-1:0];
            r_o_stored <= r_store;
        end
    end

    assign o_valid = r_out_valid;
    assign o_hit = r_o_hit;
    assign o_slot = r_o_slot;
    assign o_stored = r_o_stored;

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_op == lfatc_pkg::OP_CLEAR) |=> (r_slot_valid == '0))
        else $error("slots still valid after a clear request");

    a_pick_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lfatc_pkg::S_WRITE) |-> (CNT_W'(w_pick) < w_active))
        else $error("picked slot lies beyond the slots in use");

    a_pick_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lfatc_pkg::S_WRITE) |=> r_slot_valid[r_pick])
        else $error("used slot not marked valid");

    a_hit_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_o_stored) |-> (!r_o_hit && r_o_slot == '0))
        else $error("result reports a slot although nothing was stored");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> (r_out_valid && $stable(r_o_slot)))
        else $error("waiting result overwritten");

endmodule
